// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; every assertion is clocked and has an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define GBN_ASSERT_CR(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("gbn assertion failed");

// Short form for files that use clk and arst_n.
`define GBN_ASSERT(lbl, prop) `GBN_ASSERT_CR(lbl, clk, arst_n, prop)

`endif

// File: rtl/gbn_pkg.sv
// Package for the greedy box NMS block: sizes, register codes, payload types,
// controller state and the command/status structs. Depends on nothing.
package gbn_pkg;

	localparam int MAX_CAND   = 256;
	localparam int IDX_W      = $clog2(MAX_CAND);
	localparam int CNT_W      = $clog2(MAX_CAND + 1);
	localparam int RESULT_CAP = 64;
	localparam int DET_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int ROW_W      = 90;

	localparam logic [CFG_IDX_W-1:0] CFG_CONF   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IOU    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXDET = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AGN    = 2'd3;

	localparam logic [15:0]      CONF_RST   = 16'd16384;
	localparam logic [16:0]      IOU_RST    = 17'd29491;
	localparam logic [DET_W-1:0] MAXDET_RST = 7'd64;

	typedef struct packed {
		logic signed [15:0] box_x;
		logic signed [15:0] box_y;
		logic signed [15:0] box_w;
		logic signed [15:0] box_h;
		logic        [15:0] score;
		logic        [9:0]  cls_num;
		logic               last;
	} cand_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic        [14:0] out_w;
		logic        [14:0] out_h;
		logic        [15:0] out_score;
		logic        [9:0]  out_class;
		logic               out_last;
		logic               empty_res;
	} det_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_DECIDE,
		ST_CHECK,
		ST_FINAL,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic load_en;
		logic scan_init;
		logic scan_issue;
		logic take_best;
		logic emit;
		logic emit_empty;
		logic emit_last;
		logic frame_clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cand_fire;
		logic cand_last;
		logic scan_end;
		logic pipe_empty;
		logic best_valid;
		logic anchor_valid;
		logic at_limit;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/gbn_ctrl.sv
// Controller state machine: load, scan passes, emission and frame clear.
// Depends on gbn_pkg.
module gbn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  gbn_pkg::dp_stat_t  stat,
	output gbn_pkg::ctrl_cmd_t cmd
);

	gbn_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gbn_pkg::ST_LOAD: begin
				if (stat.cand_fire && stat.cand_last) state_nxt = gbn_pkg::ST_SCAN_INIT;
			end
			gbn_pkg::ST_SCAN_INIT: state_nxt = gbn_pkg::ST_SCAN;
			gbn_pkg::ST_SCAN: begin
				if (stat.scan_end && stat.pipe_empty) state_nxt = gbn_pkg::ST_DECIDE;
			end
			gbn_pkg::ST_DECIDE: begin
				if (stat.out_free) begin
					state_nxt = stat.best_valid ? gbn_pkg::ST_CHECK : gbn_pkg::ST_CLEAR;
				end
			end
			gbn_pkg::ST_CHECK: begin
				state_nxt = stat.at_limit ? gbn_pkg::ST_FINAL : gbn_pkg::ST_SCAN_INIT;
			end
			gbn_pkg::ST_FINAL: begin
				if (stat.out_free) state_nxt = gbn_pkg::ST_CLEAR;
			end
			gbn_pkg::ST_CLEAR: state_nxt = gbn_pkg::ST_LOAD;
			default: state_nxt = gbn_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			gbn_pkg::ST_LOAD:      cmd.load_en = 1'b1;
			gbn_pkg::ST_SCAN_INIT: cmd.scan_init = 1'b1;
			gbn_pkg::ST_SCAN:      cmd.scan_issue = 1'b1;
			gbn_pkg::ST_DECIDE: begin
				if (stat.out_free) begin
					cmd.take_best  = stat.best_valid;
					cmd.emit       = stat.anchor_valid || !stat.best_valid;
					cmd.emit_empty = !stat.anchor_valid && !stat.best_valid;
					cmd.emit_last  = !stat.best_valid;
				end
			end
			gbn_pkg::ST_CHECK: ;
			gbn_pkg::ST_FINAL: begin
				cmd.emit      = stat.out_free;
				cmd.emit_last = stat.out_free;
			end
			gbn_pkg::ST_CLEAR: cmd.frame_clear = 1'b1;
			default: ;
		endcase
	end

endmodule

// File: rtl/gbn_dp.sv
// Datapath: config registers, candidate store, overlap pipeline, suppression
// flags, anchor and output register. Depends on gbn_pkg and gbn_ram.
module gbn_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cand_valid,
	input  gbn_pkg::cand_t                   cand,
	output logic                             det_valid,
	input  logic                             det_ready,
	output gbn_pkg::det_t                    det,
	input  logic                             cfg_we,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [gbn_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  gbn_pkg::ctrl_cmd_t               cmd,
	output gbn_pkg::dp_stat_t                stat
);

	localparam int SC_LO = 64;
	localparam int CL_LO = 80;

	// configuration
	logic [15:0]               conf_q;
	logic [16:0]               iou_q;
	logic [gbn_pkg::DET_W-1:0] maxdet_q;
	logic                      agn_q;
	logic [gbn_pkg::DET_W-1:0] lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q   <= gbn_pkg::CONF_RST;
			iou_q    <= gbn_pkg::IOU_RST;
			maxdet_q <= gbn_pkg::MAXDET_RST;
			agn_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gbn_pkg::CFG_CONF:   conf_q   <= cfg_data[15:0];
				gbn_pkg::CFG_IOU:    iou_q    <= cfg_data;
				gbn_pkg::CFG_MAXDET: maxdet_q <= cfg_data[gbn_pkg::DET_W-1:0];
				gbn_pkg::CFG_AGN:    agn_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (maxdet_q == '0) begin
			lim = gbn_pkg::DET_W'(1);
		end else if (maxdet_q > gbn_pkg::DET_W'(gbn_pkg::RESULT_CAP)) begin
			lim = gbn_pkg::DET_W'(gbn_pkg::RESULT_CAP);
		end else begin
			lim = maxdet_q;
		end
	end

	// loading
	logic [gbn_pkg::CNT_W-1:0] kept_q;
	logic                      fire, pass, we;
	logic [gbn_pkg::ROW_W-1:0] wrow, rd;
	logic [gbn_pkg::CNT_W-1:0] j_q;

	assign fire = cand_valid && cmd.load_en;
	assign pass = (cand.score >= conf_q) && (cand.box_w > 16'sd0) && (cand.box_h > 16'sd0)
		&& (kept_q < gbn_pkg::CNT_W'(gbn_pkg::MAX_CAND));
	assign we   = fire && pass;
	assign wrow = {cand.cls_num, cand.score, cand.box_h, cand.box_w, cand.box_y, cand.box_x};

	gbn_ram #(.WIDTH(gbn_pkg::ROW_W), .DEPTH(gbn_pkg::MAX_CAND)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (kept_q[gbn_pkg::IDX_W-1:0]),
		.wdata (wrow),
		.raddr (j_q[gbn_pkg::IDX_W-1:0]),
		.rdata (rd)
	);

	// anchor and best candidate
	logic [gbn_pkg::ROW_W-1:0] a_row_q, best_row_q;
	logic [29:0]               a_area_q, best_area_q;
	logic                      a_valid_q, best_valid_q;
	logic [gbn_pkg::IDX_W-1:0] best_idx_q;
	logic [gbn_pkg::DET_W-1:0] cnt_q;

	// scan pipeline
	logic                      issue, scan_end;
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [gbn_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [gbn_pkg::ROW_W-1:0] row_s2, row_s3, row_s4, row_s5;
	logic                      match_s2, match_s3, match_s4, match_s5;
	logic                      done_s2, done_s3, done_s4, done_s5;
	logic [14:0]               iw_s2, ih_s2;
	logic [29:0]               barea_s2, barea_s3, barea_s4, barea_s5;
	logic [29:0]               inter_s3, inter_s4, inter_s5;
	logic signed [31:0]        uni_s4;
	logic                      upos_s5;
	logic [47:0]               prod_s5;

	assign scan_end = (j_q == kept_q);
	assign issue    = cmd.scan_issue && !scan_end;

	// suppression flags: read beside the store, rewritten to zero by the
	// first pass of a frame, which runs before any anchor exists
	logic                      done_we, done_wbit, done_rd;
	logic [gbn_pkg::IDX_W-1:0] done_waddr;

	gbn_ram #(.WIDTH(1), .DEPTH(gbn_pkg::MAX_CAND)) u_done (
		.clk   (clk),
		.we    (done_we),
		.waddr (done_waddr),
		.wdata (done_wbit),
		.raddr (j_q[gbn_pkg::IDX_W-1:0]),
		.rdata (done_rd)
	);

	// stage 1 geometry
	logic signed [15:0] ax, ay, aw, ah, bx, by, bw, bh;
	logic signed [16:0] ax2, ay2, bx2, by2, x1, y1, x2, y2;
	logic signed [17:0] dx, dy;
	logic               match;

	always_comb begin
		ax = a_row_q[15:0];  ay = a_row_q[31:16];
		aw = a_row_q[47:32]; ah = a_row_q[63:48];
		bx = rd[15:0];       by = rd[31:16];
		bw = rd[47:32];      bh = rd[63:48];
		ax2 = {ax[15], ax} + {aw[15], aw};
		ay2 = {ay[15], ay} + {ah[15], ah};
		bx2 = {bx[15], bx} + {bw[15], bw};
		by2 = {by[15], by} + {bh[15], bh};
		x1 = (ax > bx) ? {ax[15], ax} : {bx[15], bx};
		y1 = (ay > by) ? {ay[15], ay} : {by[15], by};
		x2 = (ax2 < bx2) ? ax2 : bx2;
		y2 = (ay2 < by2) ? ay2 : by2;
		dx = {x2[16], x2} - {x1[16], x1};
		dy = {y2[16], y2} - {y1[16], y1};
		match = agn_q || (rd[CL_LO+9:CL_LO] == a_row_q[CL_LO+9:CL_LO]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= j_q[gbn_pkg::IDX_W-1:0];
		idx_s2   <= idx_s1;
		row_s2   <= rd;
		match_s2 <= match;
		done_s2  <= a_valid_q && done_rd;
		iw_s2    <= (!dx[17] && dx != '0) ? dx[14:0] : 15'd0;
		ih_s2    <= (!dy[17] && dy != '0) ? dy[14:0] : 15'd0;
		barea_s2 <= bw[14:0] * bh[14:0];
		idx_s3   <= idx_s2;
		row_s3   <= row_s2;
		match_s3 <= match_s2;
		done_s3  <= done_s2;
		barea_s3 <= barea_s2;
		inter_s3 <= iw_s2 * ih_s2;
		idx_s4   <= idx_s3;
		row_s4   <= row_s3;
		match_s4 <= match_s3;
		done_s4  <= done_s3;
		barea_s4 <= barea_s3;
		inter_s4 <= inter_s3;
		uni_s4   <= signed'({2'b00, a_area_q}) + signed'({2'b00, barea_s3})
			- signed'({2'b00, inter_s3});
		idx_s5   <= idx_s4;
		row_s5   <= row_s4;
		match_s5 <= match_s4;
		done_s5  <= done_s4;
		barea_s5 <= barea_s4;
		inter_s5 <= inter_s4;
		upos_s5  <= (uni_s4 > 32'sd0);
		prod_s5  <= iou_q * uni_s4[30:0];
	end

	// stage 5 decision
	logic [47:0] lhs;
	logic        ovl, live;

	assign lhs  = {2'b00, inter_s5, 16'h0000};
	assign ovl  = a_valid_q && match_s5 && (upos_s5 ? (lhs >= prod_s5) : (iou_q == '0));
	assign live = v_s5 && !done_s5;

	// flag writes: the emitted box, a suppressed box, or a zero on the first pass
	assign done_we    = cmd.take_best || (v_s5 && !a_valid_q) || (live && ovl);
	assign done_waddr = cmd.take_best ? best_idx_q : idx_s5;
	assign done_wbit  = cmd.take_best || ovl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q       <= '0;
			j_q          <= '0;
			a_valid_q    <= 1'b0;
			best_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (we) kept_q <= kept_q + 1'b1;
			if (cmd.scan_init) begin
				j_q          <= '0;
				best_valid_q <= 1'b0;
			end else if (issue) begin
				j_q <= j_q + 1'b1;
			end
			if (live && !ovl && (!best_valid_q
				|| row_s5[SC_LO+15:SC_LO] > best_row_q[SC_LO+15:SC_LO])) begin
				best_valid_q <= 1'b1;
			end
			if (cmd.take_best) begin
				a_valid_q <= 1'b1;
				cnt_q     <= cnt_q + 1'b1;
			end
			if (cmd.frame_clear) begin
				kept_q    <= '0;
				a_valid_q <= 1'b0;
				cnt_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (live && !ovl && (!best_valid_q
			|| row_s5[SC_LO+15:SC_LO] > best_row_q[SC_LO+15:SC_LO])) begin
			best_row_q  <= row_s5;
			best_idx_q  <= idx_s5;
			best_area_q <= barea_s5;
		end
		if (cmd.take_best) begin
			a_row_q  <= best_row_q;
			a_area_q <= best_area_q;
		end
	end

	// output register
	logic          out_valid_q;
	gbn_pkg::det_t out_q, out_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (det_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_d = '0;
		if (!cmd.emit_empty) begin
			out_d.out_x     = a_row_q[15:0];
			out_d.out_y     = a_row_q[31:16];
			out_d.out_w     = a_row_q[46:32];
			out_d.out_h     = a_row_q[62:48];
			out_d.out_score = a_row_q[SC_LO+15:SC_LO];
			out_d.out_class = a_row_q[CL_LO+9:CL_LO];
		end
		out_d.out_last  = cmd.emit_last;
		out_d.empty_res = cmd.emit_empty;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= out_d;
		end
	end

	assign det_valid = out_valid_q;
	assign det       = out_q;

	always_comb begin
		stat.cand_fire    = fire;
		stat.cand_last    = cand.last;
		stat.scan_end     = scan_end;
		stat.pipe_empty   = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5);
		stat.best_valid   = best_valid_q;
		stat.anchor_valid = a_valid_q;
		stat.at_limit     = (cnt_q >= lim);
		stat.out_free     = !out_valid_q;
	end

endmodule

// File: rtl/greedy_box_nms_top.sv
// Top level of the greedy box NMS block: controller plus datapath.
// Depends on gbn_pkg, gbn_ctrl, gbn_dp (and through it gbn_ram).
//
// Greedy non-maximum suppression over one frame of detection candidates.
// Candidates stream in on the cand channel, one per cycle, until a transaction
// with last set; cand_ready is high only in the load phase. Candidates under
// the confidence threshold, or with zero or negative width or height, are
// dropped; up to 256 are kept in a one-write, one-read candidate store, and
// further passing candidates of the frame are ignored. After the last
// candidate the block stops accepting input and runs scan passes over the
// store: each pass reads every kept candidate once through a five-stage
// overlap pipeline (geometry, area, intersection, union, cross-multiplied IoU
// compare), suppresses boxes that overlap the current kept box, and finds the
// highest-scoring survivor (earliest wins on ties), which becomes the next
// detection. Each pass has a start step, one read per kept box, a drain of the
// pipeline, a decide step and a check of the detection limit; the decide step
// also waits while the output register still holds an unaccepted detection.
// After the last pass of a frame a clear step resets the counters. The
// suppression flags sit in a small RAM beside the store and are rewritten by
// the first pass of every frame. Detections leave through an output register
// on the det channel; the final one of the frame has out_last set, and a frame
// with no survivor gives one transaction with empty_res and out_last set and
// every other field zero. Registers on the cfg port: 0 confidence threshold,
// 1 IoU threshold, 2 max detections (0 acts as 1, above 64 acts as 64),
// 3 class-agnostic mode. Write them only while the block is idle.
module greedy_box_nms_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cand_valid,
	output logic                           cand_ready,
	input  gbn_pkg::cand_t                 cand,
	output logic                           det_valid,
	input  logic                           det_ready,
	output gbn_pkg::det_t                  det,
	input  logic                           cfg_we,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data
);

	gbn_pkg::ctrl_cmd_t cmd;
	gbn_pkg::dp_stat_t  stat;

	// Accept candidates only while the controller sits in the load phase.
	assign cand_ready = cmd.load_en;

	gbn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	gbn_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand       (cand),
		.det_valid  (det_valid),
		.det_ready  (det_ready),
		.det        (det),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

// File: rtl/gbn_chk.sv
// Port-level checker for greedy_box_nms_top, attached by bind below.
// Depends on gbn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gbn_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          det_valid,
	input logic          det_ready,
	input gbn_pkg::det_t det
);

	// hold a stalled detection
	`GBN_ASSERT(a_det_hold, det_valid && !det_ready |=> det_valid && $stable(det))
	// an empty frame result is always the final one
	`GBN_ASSERT(a_empty_last, det_valid && det.empty_res |-> det.out_last)
	// an empty result carries zero width and score
	`GBN_ASSERT(a_empty_zero, det_valid && det.empty_res |-> det.out_w == '0 && det.out_score == '0)
	// a real detection has positive extent
	`GBN_ASSERT(a_det_size, det_valid && !det.empty_res |-> det.out_w != '0 && det.out_h != '0)

endmodule

bind greedy_box_nms_top gbn_chk u_chk (.*);

// File: tb/tb_greedy_box_nms_top.sv
// Self-checking testbench for greedy_box_nms_top: streams candidate frames, predicts the kept
// detections per frame and checks every det transaction in order.
// Depends on gbn_pkg and greedy_box_nms_top.
module tb_greedy_box_nms_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_WAIT  = 40;	// covers the return to the load phase
	localparam int HOLD_CYCLES = 400;	// long receiver hold-off

	// Frame model: collects the kept candidates, runs the greedy pass on the
	// last one and queues the detections that the block must produce.
	class det_scoreboard;
		gbn_pkg::cand_t kept[$];
		gbn_pkg::det_t  pending[$];
		logic [15:0] conf_thr = gbn_pkg::CONF_RST;
		logic [16:0] iou_thr  = gbn_pkg::IOU_RST;
		logic [6:0]  max_det  = gbn_pkg::MAXDET_RST;
		bit          agnostic = 0;
		int          errors   = 0;

		function bit hits(gbn_pkg::cand_t a, gbn_pkg::cand_t b);
			int     x1, y1, x2, y2;
			longint iw, ih, inter, uni;
			x1 = a.box_x > b.box_x ? a.box_x : b.box_x;
			y1 = a.box_y > b.box_y ? a.box_y : b.box_y;
			x2 = (int'(a.box_x) + a.box_w) < (int'(b.box_x) + b.box_w) ?
				(int'(a.box_x) + a.box_w) : (int'(b.box_x) + b.box_w);
			y2 = (int'(a.box_y) + a.box_h) < (int'(b.box_y) + b.box_h) ?
				(int'(a.box_y) + a.box_h) : (int'(b.box_y) + b.box_h);
			iw = x2 - x1 > 0 ? x2 - x1 : 0;
			ih = y2 - y1 > 0 ? y2 - y1 : 0;
			inter = iw * ih;
			uni = longint'(a.box_w) * a.box_h + longint'(b.box_w) * b.box_h - inter;
			if (uni <= 0)
				return iou_thr == 0;
			return inter * 65536 >= longint'(iou_thr) * uni;
		endfunction

		function void note_cand(gbn_pkg::cand_t c);
			int            ord[$];
			bit            gone[$];
			int            lim, n, j, cnt, cur;
			gbn_pkg::det_t d;
			if (c.score >= conf_thr && c.box_w > 0 && c.box_h > 0 &&
				kept.size() < gbn_pkg::MAX_CAND)
				kept.insert(kept.size(), c);
			if (!c.last)
				return;
			n = kept.size();
			// stable order by falling score
			for (int i = 0; i < n; i++) begin
				j = ord.size();
				while (j > 0 && kept[ord[j-1]].score < kept[i].score)
					j--;
				ord.insert(j, i);
				gone.insert(gone.size(), 0);
			end
			lim = max_det == 0 ? 1 :
				(max_det > gbn_pkg::RESULT_CAP ? gbn_pkg::RESULT_CAP : max_det);
			cnt = 0;
			for (int i = 0; i < n; i++) begin
				if (gone[i])
					continue;
				cur = ord[i];
				d = '0;
				d.out_x = kept[cur].box_x;
				d.out_y = kept[cur].box_y;
				d.out_w = kept[cur].box_w[14:0];
				d.out_h = kept[cur].box_h[14:0];
				d.out_score = kept[cur].score;
				d.out_class = kept[cur].cls_num;
				pending.insert(pending.size(), d);
				cnt++;
				if (cnt >= lim)
					break;
				for (int k = i + 1; k < n; k++) begin
					if (gone[k])
						continue;
					if (!agnostic && kept[cur].cls_num != kept[ord[k]].cls_num)
						continue;
					if (hits(kept[cur], kept[ord[k]]))
						gone[k] = 1;
				end
			end
			if (cnt == 0) begin
				d = '0;
				d.out_last = 1;
				d.empty_res = 1;
				pending.insert(pending.size(), d);
			end else
				pending[pending.size()-1].out_last = 1;
			kept.delete();
		endfunction

		function void check_det(gbn_pkg::det_t got);
			gbn_pkg::det_t exp;
			bit            bad;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected det transaction %p", got);
				return;
			end
			exp = pending.pop_front();
			bad = got.out_x !== exp.out_x || got.out_y !== exp.out_y ||
				got.out_w !== exp.out_w || got.out_h !== exp.out_h ||
				got.out_score !== exp.out_score || got.out_class !== exp.out_class ||
				got.out_last !== exp.out_last || got.empty_res !== exp.empty_res;
			if (bad) begin
				errors++;
				if (errors <= 10)
					$display("det mismatch: expected %p, got %p", exp, got);
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cand_valid;
	logic                           cand_ready;
	gbn_pkg::cand_t                 cand;
	logic                           det_valid;
	logic                           det_ready;
	gbn_pkg::det_t                  det;
	logic                           cfg_we;
	logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data;

	det_scoreboard sb = new();
	int cycles;
	int hold_reqs, holds_served;	// main bumps hold_reqs; receiver serves it
	int quiet_left, calm_left;
	int sent;

	greedy_box_nms_top dut (
		.clk(clk), .arst_n(arst_n),
		.cand_valid(cand_valid), .cand_ready(cand_ready), .cand(cand),
		.det_valid(det_valid), .det_ready(det_ready), .det(det),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Watchdog: count cycles and abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: mostly ready, short and long stalls, calm stretches with no
	// stall, and a long hold-off whenever the main thread asks for one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_ready <= 0;
			holds_served <= 0;
			quiet_left <= 0;
			calm_left <= 0;
		end else if (holds_served != hold_reqs) begin
			holds_served <= hold_reqs;
			quiet_left <= HOLD_CYCLES;
			det_ready <= 0;
		end else if (quiet_left > 0) begin
			quiet_left <= quiet_left - 1;
			det_ready <= 0;
		end else if (calm_left > 0) begin
			calm_left <= calm_left - 1;
			det_ready <= 1;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:64]:  det_ready <= 1;
				[65:89]: begin
					det_ready <= 0;
					quiet_left <= $urandom_range(1, 3);
				end
				[90:96]: begin
					det_ready <= 0;
					quiet_left <= $urandom_range(10, 60);
				end
				default: begin
					det_ready <= 1;
					calm_left <= 200;
				end
			endcase
		end
	end

	// Monitor: check every det transaction at the edge that accepts it.
	always @(posedge clk)
		if (arst_n && det_valid && det_ready)
			sb.check_det(det);

	function automatic gbn_pkg::cand_t mk(int x, int y, int w, int h, int s, int cls, bit lst);
		gbn_pkg::cand_t c;
		c.box_x = 16'(x);
		c.box_y = 16'(y);
		c.box_w = 16'(w);
		c.box_h = 16'(h);
		c.score = 16'(s);
		c.cls_num = 10'(cls);
		c.last = lst;
		return c;
	endfunction

	// Offer one candidate and hold it until the transaction completes; the
	// valid stays high into the next item when no gap follows. Drop valid
	// after the last item of a frame, even when no gap is asked for.
	task automatic send(gbn_pkg::cand_t c, int gap);
		cand_valid <= 1;
		cand <= c;
		@(posedge clk);
		while (!cand_ready)
			@(posedge clk);
		sb.note_cand(c);
		sent++;
		if (gap > 0 || c.last) begin
			cand_valid <= 0;
			repeat ((gap > 0) ? gap : 1)
				@(posedge clk);
		end
	endtask

	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Wait until every expected detection is out, then let the block settle.
	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [gbn_pkg::CFG_IDX_W-1:0] idx, int val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= gbn_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			gbn_pkg::CFG_CONF:   sb.conf_thr = 16'(val);
			gbn_pkg::CFG_IOU:    sb.iou_thr = 17'(val);
			gbn_pkg::CFG_MAXDET: sb.max_det = 7'(val);
			gbn_pkg::CFG_AGN:    sb.agnostic = val[0];
		endcase
		@(posedge clk);
	endtask

	task automatic random_frame(int len, bit calm);
		int ax, ay;
		gbn_pkg::cand_t c;
		ax = $urandom_range(0, 4000) - 2000;
		ay = $urandom_range(0, 4000) - 2000;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				// clustered boxes around one anchor so that overlaps happen
				c = mk(ax + $urandom_range(0, 64) - 32, ay + $urandom_range(0, 64) - 32,
					$urandom_range(16, 400), $urandom_range(16, 400),
					$urandom_range(sb.conf_thr, 65535), $urandom_range(0, 3), 0);
			end else
				c = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
			c.last = (i == len - 1);
			send(c, pick_gap(calm));
		end
	endtask

	initial begin
		int rand_sent, frames;
		cycles = 0;
		hold_reqs = 0;
		sent = 0;
		arst_n = 0;
		cand_valid <= 0;
		cand <= '0;
		cfg_we <= 0;
		cfg_idx <= gbn_pkg::CFG_CONF;
		cfg_data <= '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Nothing survives: a single score under the threshold.
		send(mk(0, 0, 16, 16, 0, 5, 1), 0);
		drain();

		// Extreme fields, dropped widths and heights, a tie, a same-class
		// overlap, a different-class twin and a score right at the threshold.
		send(mk(-32768, -32768, 32767, 32767, 65535, 1023, 0), 0);
		send(mk(32767, 32767, -32768, 5, 65535, 0, 0), 1);
		send(mk(100, 100, 0, 50, 50000, 3, 0), 0);
		send(mk(100, 100, 50, -1, 50000, 3, 0), 0);
		send(mk(100, 100, 160, 160, 40000, 3, 0), 2);
		send(mk(104, 100, 160, 160, 40000, 3, 0), 0);
		send(mk(100, 100, 160, 160, 30000, 4, 0), 0);
		send(mk(0, 0, 1, 1, 16384, 3, 1), 0);
		drain();

		// Cross-class suppression at full IoU threshold.
		write_reg(gbn_pkg::CFG_AGN, 1);
		write_reg(gbn_pkg::CFG_IOU, 65536);
		send(mk(100, 100, 160, 160, 40000, 3, 0), 0);
		send(mk(100, 100, 160, 160, 39000, 4, 0), 0);
		send(mk(120, 100, 160, 160, 38000, 7, 1), 0);
		drain();

		// Zero IoU threshold and zero max detections (acts as one).
		write_reg(gbn_pkg::CFG_IOU, 0);
		write_reg(gbn_pkg::CFG_MAXDET, 0);
		send(mk(0, 0, 32, 32, 20000, 1, 0), 0);
		send(mk(5000, 5000, 32, 32, 60000, 2, 0), 0);
		send(mk(-900, 40, 32, 32, 30000, 1, 1), 0);
		drain();

		// Threshold above one never suppresses; max detections over the cap.
		write_reg(gbn_pkg::CFG_IOU, 131071);
		write_reg(gbn_pkg::CFG_MAXDET, 127);
		write_reg(gbn_pkg::CFG_AGN, 0);
		write_reg(gbn_pkg::CFG_CONF, 0);
		send(mk(10, 10, 64, 64, 0, 9, 0), 0);
		send(mk(10, 10, 64, 64, 0, 9, 0), 0);
		send(mk(12, 10, 64, 64, 1, 9, 1), 0);
		drain();

		write_reg(gbn_pkg::CFG_CONF, 65535);
		send(mk(10, 10, 64, 64, 65534, 9, 0), 0);
		send(mk(10, 10, 64, 64, 65535, 9, 1), 0);
		drain();

		write_reg(gbn_pkg::CFG_CONF, 16384);
		write_reg(gbn_pkg::CFG_IOU, 29491);
		write_reg(gbn_pkg::CFG_MAXDET, 64);

		// Random frames, with a new register setting every few frames.
		rand_sent = 0;
		frames = 0;
		while (rand_sent < 160) begin
			int len, before_cnt;
			if (frames % 4 == 3) begin
				drain();
				write_reg(gbn_pkg::CFG_CONF, $urandom_range(0, 3) == 0 ?
					$urandom_range(0, 65535) : $urandom_range(0, 20000));
				write_reg(gbn_pkg::CFG_IOU, $urandom_range(0, 4) == 0 ?
					$urandom_range(0, 131071) : $urandom_range(0, 65536));
				write_reg(gbn_pkg::CFG_MAXDET, $urandom_range(0, 5) == 0 ?
					$urandom_range(0, 127) : $urandom_range(1, 64));
				write_reg(gbn_pkg::CFG_AGN, $urandom_range(0, 1));
			end
			len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12);
			before_cnt = sent;
			random_frame(len, $urandom_range(0, 3) == 0);
			rand_sent += sent - before_cnt;
			// once, hold off the receiver while this frame emits and the next
			// frame keeps offering; otherwise sometimes pause until drained
			if (frames == 4)
				hold_reqs++;
			else if ($urandom_range(0, 2) == 0)
				drain();
			frames++;
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/gbn_pkg.sv
rtl/gbn_ram.sv
rtl/gbn_ctrl.sv
rtl/gbn_dp.sv
rtl/greedy_box_nms_top.sv
rtl/gbn_chk.sv
tb/tb_greedy_box_nms_top.sv
